// ----- rtl/ihb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ihb_pkg;

  // Header geometry
  localparam int unsigned HDR_WORDS = 5;
  localparam int unsigned SLOT_W    = 3;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HDR_WORDS - 1);

  // Fixed header content
  localparam logic [7:0]  VER_IHL   = 8'h45;
  localparam logic [15:0] HDR_BYTES = 16'd20;

  // Register reset values
  localparam logic [31:0] SOURCE_IP_RST = 32'hC0A8_0064;
  localparam logic [7:0]  TTL_RST       = 8'd64;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_SOURCE_IP = 2'd0;
  localparam cfg_idx_t REG_TTL_VALUE = 2'd1;

  typedef logic [31:0] hdr_word_t;

endpackage

`default_nettype wire

// ----- rtl/ipv4_header_builder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// IPv4 header builder. Each request transfer (destination, protocol, payload
// length) produces a 20-byte option-less IPv4 header as five 32-bit words,
// network order, first byte in bits 31:24, with out_last_word set on the
// fifth. Total length is 20 + payload length wrapped to 16 bits;
// out_length_overflow is set on all five words when the wrap happens. The
// identification field comes from a 16-bit counter that starts at zero after
// reset and wraps. TTL and source address come from two registers written on
// the cfg port (index 0 source address, index 1 TTL; other indices ignored),
// which should only be written while the block is idle.
// Throughput is set by the 32-bit result channel, five word transfers per
// header. A request passes from an input register into the header buffer,
// loaded in one pass that also forms the checksum. A new request is taken
// into the input register while the previous header is still draining, so
// back-to-back requests leave no gap on the result channel.
module ipv4_header_builder_top
  import ihb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_write_en,
  input  wire cfg_idx_t    cfg_index,
  input  wire logic [31:0] cfg_data,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_dest_ip,
  input  wire logic [7:0]  in_protocol,
  input  wire logic [15:0] in_payload_length,
  // header word channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_header_word,
  output logic             out_last_word,
  output logic             out_length_overflow
);

  // config registers
  logic [31:0] source_ip_r;
  logic [7:0]  ttl_r;

  // input register
  logic        in_full_r;
  logic [31:0] dest_r;
  logic [7:0]  proto_r;
  logic [15:0] plen_r;

  // header buffer and serialiser
  logic              hdr_full_r;
  hdr_word_t         hdr_r [HDR_WORDS];
  logic              ovf_r;
  logic [SLOT_W-1:0] slot_r;
  logic [15:0]       ident_r;

  logic in_xfer, out_xfer, hdr_done, hdr_load;

  // header build
  logic [16:0] full_len;
  logic [15:0] total_len;
  logic [19:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] csum;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign hdr_done = out_xfer && (slot_r == LAST_SLOT);
  // move the held request into the buffer once the buffer is empty or its
  // last word leaves this cycle
  assign hdr_load = in_full_r && (!hdr_full_r || hdr_done);
  assign in_ready = !in_full_r || hdr_load;

  assign full_len  = 17'(HDR_BYTES) + 17'(plen_r);
  assign total_len = full_len[15:0];

  // ones'-complement sum of the eight non-zero halves (TOS, flags and
  // checksum fields are zero); at most 8 * 0xFFFF, so 20 bits hold it
  assign sum = 20'({VER_IHL, 8'h00}) + 20'(total_len) + 20'(ident_r)
             + 20'({ttl_r, proto_r})
             + 20'(source_ip_r[31:16]) + 20'(source_ip_r[15:0])
             + 20'(dest_r[31:16]) + 20'(dest_r[15:0]);
  // two end-around folds settle it: after the first the carry is 0 or 1
  // and the low half is then small
  assign fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);
  assign csum  = ~fold2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_ip_r <= SOURCE_IP_RST;
      ttl_r       <= TTL_RST;
      in_full_r   <= 1'b0;
      hdr_full_r  <= 1'b0;
      slot_r      <= '0;
      ident_r     <= '0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          REG_SOURCE_IP: source_ip_r <= cfg_data;
          REG_TTL_VALUE: ttl_r       <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (in_xfer) begin
        in_full_r <= 1'b1;
      end else if (hdr_load) begin
        in_full_r <= 1'b0;
      end

      if (hdr_load) begin
        hdr_full_r <= 1'b1;
        ident_r    <= ident_r + 16'd1;
      end else if (hdr_done) begin
        hdr_full_r <= 1'b0;
      end

      if (hdr_done) begin
        slot_r <= '0;
      end else if (out_xfer) begin
        slot_r <= slot_r + SLOT_W'(1);
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      dest_r  <= in_dest_ip;
      proto_r <= in_protocol;
      plen_r  <= in_payload_length;
    end
    if (hdr_load) begin
      hdr_r[0] <= {VER_IHL, 8'h00, total_len};
      hdr_r[1] <= {ident_r, 16'h0000};
      hdr_r[2] <= {ttl_r, proto_r, csum};
      hdr_r[3] <= source_ip_r;
      hdr_r[4] <= dest_r;
      ovf_r    <= full_len[16];
    end
  end

  assign out_valid           = hdr_full_r;
  assign out_header_word     = hdr_r[slot_r];
  assign out_last_word       = (slot_r == LAST_SLOT);
  assign out_length_overflow = ovf_r;

endmodule

`default_nettype wire

// ----- rtl/ihb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ihb_checker
  import ihb_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_header_word,
  input wire logic        out_last_word,
  input wire logic        out_length_overflow
);

  logic              out_xfer;
  logic [SLOT_W-1:0] cnt_r;
  logic              ovf_seen_r;

  assign out_xfer = out_valid && out_ready;

  // words seen in the current header, and its overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      ovf_seen_r <= 1'b0;
    end else if (out_xfer) begin
      cnt_r      <= out_last_word ? '0 : cnt_r + SLOT_W'(1);
      ovf_seen_r <= out_length_overflow;
    end
  end

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_header_word)
      && $stable(out_last_word))
    else $error("header word changed while stalled");

  // last marker on exactly the fifth word
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (cnt_r == LAST_SLOT)))
    else $error("last word marker out of place");

  // first word carries version, IHL and zero TOS
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cnt_r == '0 |-> out_header_word[31:16] == {VER_IHL, 8'h00})
    else $error("first word lacks version/IHL");

  // overflow flag constant across one header
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cnt_r != '0 |-> out_length_overflow == ovf_seen_r)
    else $error("overflow flag changed within a header");

  // nothing offered straight out of reset
  a_rst: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind ipv4_header_builder_top ihb_checker u_ihb_checker (.*);

`default_nettype wire

// ----- dv/ipv4_header_builder_top_tb.sv -----
`timescale 1ns / 1ps

// Block-level bench for the IPv4 header builder.
// A request is pushed through the in_ channel and, at the moment the transfer
// happens, the bench builds the five header words it should produce (own
// identification counter, own copy of the source/TTL registers, own checksum)
// and queues them. Every out_ transfer is checked against the oldest queued
// word. Both channels idle at random; registers change only with the block idle.
module ipv4_header_builder_top_tb;
  import ihb_pkg::*;

  // Spare register indices: the block must ignore writes to these
  localparam cfg_idx_t REG_SPARE_A = 2'd2;
  localparam cfg_idx_t REG_SPARE_B = 2'd3;

  // Payload lengths either side of the 16-bit total length limit
  localparam logic [15:0] MAX_FIT_LEN  = 16'hFFFF - HDR_BYTES;
  localparam logic [15:0] MIN_WRAP_LEN = 16'hFFFF - HDR_BYTES + 16'd1;
  localparam logic [15:0] MAX_LEN      = 16'hFFFF;

  // Header passes an input register and a buffer; allow plenty once the last word has gone
  localparam int SETTLE_CYCLES = 8;
  // Slowest run: ~210 headers, each word possibly stalled, plus sender gaps;
  // the limit allows for that many times over
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int MAX_REPORTS   = 40;
  localparam int B2B_REQUESTS  = 16;

  typedef struct packed {
    hdr_word_t word;
    logic      last;
    logic      ovf;
  } header_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        cfg_write_en = 1'b0;
  cfg_idx_t    cfg_index = REG_SOURCE_IP;
  logic [31:0] cfg_data = '0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_dest_ip = '0;
  logic [7:0]  in_protocol = '0;
  logic [15:0] in_payload_length = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_header_word;
  logic        out_last_word;
  logic        out_length_overflow;

  ipv4_header_builder_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_write_en        (cfg_write_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_dest_ip          (in_dest_ip),
    .in_protocol         (in_protocol),
    .in_payload_length   (in_payload_length),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_header_word     (out_header_word),
    .out_last_word       (out_last_word),
    .out_length_overflow (out_length_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the block state
  logic [31:0]  src_addr_model = SOURCE_IP_RST;
  logic [7:0]   ttl_model      = TTL_RST;
  logic [15:0]  next_ident     = '0;
  header_beat_t pending_beats[$];

  int err_count   = 0;
  int cycle_count = 0;

  // Sender burst control
  int burst_left = 0;
  bit gaps_on    = 1'b1;

  // Receiver stall pattern
  bit         rx_full_rate = 1'b0;
  int         rx_left  = 0;
  int         rx_mode  = 0;
  int         rx_stall = 0;
  logic [7:0] rx_mask  = 8'hFF;
  logic [2:0] rx_phase = '0;

  header_beat_t got_beat;

  // Work out the header for one accepted request and queue its five words.
  function automatic void build_header(input logic [31:0] dst, input logic [7:0] proto,
                                       input logic [15:0] plen);
    logic [16:0] full_len;
    logic [15:0] ident;
    logic [31:0] acc;
    hdr_word_t   w [HDR_WORDS];
    header_beat_t beat;
    int k;
    full_len   = {1'b0, plen} + {1'b0, HDR_BYTES};
    ident      = next_ident;
    next_ident = next_ident + 16'd1;
    w[0] = {VER_IHL, 8'h00, full_len[15:0]};
    w[1] = {ident, 16'h0000};
    w[2] = {ttl_model, proto, 16'h0000};
    w[3] = src_addr_model;
    w[4] = dst;
    // ones' complement sum over the ten halves, checksum field as zero
    acc = '0;
    for (k = 0; k < HDR_WORDS; k++) begin
      acc = acc + {16'h0000, w[k][31:16]} + {16'h0000, w[k][15:0]};
    end
    while (acc[31:16] != 16'h0000) begin
      acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
    end
    w[2][15:0] = ~acc[15:0];
    for (k = 0; k < HDR_WORDS; k++) begin
      beat.word = w[k];
      beat.last = (k == HDR_WORDS - 1);
      beat.ovf  = full_len[16];
      pending_beats.push_back(beat);
    end
  endfunction

  function automatic void note_mismatch(input string field, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $error("%s: expected 0x%08h, got 0x%08h", field, exp_val, act_val);
    end
  endfunction

  // Result checker: every word transfer against the oldest queued word
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS) begin
          $error("out_header_word: no word expected, got 0x%08h", out_header_word);
        end
      end else begin
        got_beat = pending_beats.pop_front();
        if (out_header_word !== got_beat.word) begin
          note_mismatch("out_header_word", got_beat.word, out_header_word);
        end
        if (out_last_word !== got_beat.last) begin
          note_mismatch("out_last_word", {31'd0, got_beat.last}, {31'd0, out_last_word});
        end
        if (out_length_overflow !== got_beat.ovf) begin
          note_mismatch("out_length_overflow", {31'd0, got_beat.ovf},
                        {31'd0, out_length_overflow});
        end
      end
    end
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ipv4_header_builder_top_tb: FAIL");
      $finish;
    end
  end

  // Receiver: every so often picks a new stall style - always ready, a
  // rotating 8-bit mask, coin toss, or occasional long stalls
  always @(negedge clk) begin
    if (rx_full_rate) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_left <= $urandom_range(16, 80);
        rx_mask <= 8'($urandom_range(1, 255));
      end else begin
        rx_left <= rx_left - 1;
      end
      rx_phase <= rx_phase + 3'd1;
      case (rx_mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= rx_mask[rx_phase];
        end
        2: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          if (rx_stall != 0) begin
            out_ready <= 1'b0;
            rx_stall  <= rx_stall - 1;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
              rx_stall <= $urandom_range(3, 10);
            end
          end
        end
      endcase
    end
  end

  // One request transfer. Bursts of random length, random gaps between them;
  // valid stays high across back-to-back requests within a burst.
  task automatic send_request(input logic [31:0] dst, input logic [7:0] proto,
                              input logic [15:0] plen);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end else if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_dest_ip        <= dst;
    in_protocol       <= proto;
    in_payload_length <= plen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    build_header(dst, proto, plen);
  endtask

  // Let every queued word come out, then wait out SETTLE_CYCLES, so the block is idle
  task automatic drain_headers();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    if (idx == REG_SOURCE_IP) begin
      src_addr_model = data;
    end else if (idx == REG_TTL_VALUE) begin
      ttl_model = data[7:0];
    end
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  function automatic logic [15:0] pick_payload_len();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 1500));
      2: return 16'($urandom_range(65490, 65535));
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'd0;
          1: return MAX_FIT_LEN;
          2: return MIN_WRAP_LEN;
          default: return MAX_LEN;
        endcase
      end
    endcase
  endfunction

  task automatic send_random_request();
    send_request($urandom(), 8'($urandom_range(0, 255)), pick_payload_len());
  endtask

  // Reset register values and identification starting from zero
  task automatic test_reset_values();
    send_request(32'h0A00_0001, 8'd6, 16'd40);
    send_request(32'hC0A8_0001, 8'd17, 16'd512);
  endtask

  // Field extremes, including the total length wrap either side of the limit
  task automatic test_field_extremes();
    send_request(32'h0000_0000, 8'h00, 16'd0);
    send_request(32'hFFFF_FFFF, 8'hFF, MAX_FIT_LEN);
    send_request(32'h8000_0001, 8'h01, MIN_WRAP_LEN);
    send_request(32'hFFFF_FFFF, 8'hFF, MAX_LEN);
    send_request(32'h0000_0000, 8'h80, 16'd1);
  endtask

  // Both registers at zero, then all ones, then something in between
  task automatic test_register_extremes();
    drain_headers();
    write_reg(REG_SOURCE_IP, 32'h0000_0000);
    write_reg(REG_TTL_VALUE, 32'h0000_0000);
    send_request(32'h0000_0000, 8'h00, 16'd0);
    send_request(32'h1234_5678, 8'h11, 16'd1000);
    drain_headers();
    write_reg(REG_SOURCE_IP, 32'hFFFF_FFFF);
    write_reg(REG_TTL_VALUE, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 8'hFF, MAX_LEN);
    send_request(32'hFFFF_FFFF, 8'hFF, MAX_FIT_LEN);
    drain_headers();
    write_reg(REG_SOURCE_IP, 32'hAC10_0A05);
    write_reg(REG_TTL_VALUE, 32'h0000_0080);
    send_request(32'h5555_AAAA, 8'h2F, 16'd64);
  endtask

  // Writes to the spare indices must leave both registers untouched
  task automatic test_unknown_index();
    drain_headers();
    write_reg(REG_SPARE_A, $urandom());
    write_reg(REG_SPARE_B, $urandom());
    send_request(32'h0102_0304, 8'h01, 16'd8);
    send_request(32'hFEDC_BA98, 8'h3A, 16'd1280);
  endtask

  // Requests flat out with the receiver always ready: no gap between headers
  task automatic test_back_to_back();
    drain_headers();
    rx_full_rate = 1'b1;
    gaps_on      = 1'b0;
    repeat (B2B_REQUESTS) send_random_request();
    drain_headers();
    rx_full_rate = 1'b0;
    gaps_on      = 1'b1;
  endtask

  // Random traffic in four register phases; the second runs without gaps
  task automatic test_random_traffic();
    int ph;
    for (ph = 0; ph < 4; ph++) begin
      drain_headers();
      if (ph == 3) begin
        write_reg(REG_SOURCE_IP, 32'h0000_0000);
        write_reg(REG_TTL_VALUE, 32'h0000_00FF);
      end else begin
        write_reg(REG_SOURCE_IP, $urandom());
        write_reg(REG_TTL_VALUE, $urandom());
      end
      gaps_on    = (ph != 1);
      burst_left = 0;
      repeat (45) send_random_request();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_field_extremes();
    test_register_extremes();
    test_unknown_index();
    test_back_to_back();
    test_random_traffic();

    drain_headers();
    if (err_count == 0) begin
      $display("ipv4_header_builder_top_tb: PASS");
    end else begin
      $display("ipv4_header_builder_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ihb_pkg.sv
rtl/ipv4_header_builder_top.sv
rtl/ihb_checker.sv
dv/ipv4_header_builder_top_tb.sv
